>>> sv/ips_patch_stream_parser_defines.svh
// assertion macros for the ips patch stream parser
// no dependencies; included by the top level
`ifndef IPS_PATCH_STREAM_PARSER_DEFINES_SVH
`define IPS_PATCH_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipsp assertion failed");

// next-cycle implication, checked out of reset
`define IPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipsp assertion failed");

`endif

>>> sv/ipsp_pkg.sv
// shared types and constants of the ips patch stream parser
// no dependencies
package ipsp_pkg;

    localparam int BYTE_W     = 8;
    localparam int PATCH_LEN_W = 24;
    localparam int OFFSET_W   = 24;
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 25;
    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 3;

    localparam logic [OFFSET_W-1:0]    EOF_MARK       = 24'h454F46;
    localparam logic [COUNT_W-1:0]     HEADER_LEN     = 3'd5;
    localparam logic [COUNT_W-1:0]     OFFSET_BYTES   = 3'd3;
    localparam logic [COUNT_W-1:0]     SIZE_BYTES     = 3'd2;
    localparam logic [PATCH_LEN_W-1:0] PATCH_LEN_RST  = 24'hFFFFFF;

    typedef enum logic [KIND_W-1:0] {
        K_DATA     = 3'd0,
        K_RUN      = 3'd1,
        K_END      = 3'd2,
        K_SIZE_ERR = 3'd3,
        K_TRUNC    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] patch_byte;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] target_address;
        logic [SIZE_W-1:0] run_length;
        logic [BYTE_W-1:0] byte_value;
        logic              record_end;
    } t_result;

endpackage

>>> sv/ipsp_if.sv
// valid/ready channel interfaces for patch bytes and parse results
// depends on ipsp_pkg
interface ipsp_in_if;
    import ipsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] patch_byte;
    logic              last_byte;

    modport source (output valid, output patch_byte, output last_byte, input ready);
    modport sink   (input valid, input patch_byte, input last_byte, output ready);
endinterface

interface ipsp_out_if;
    import ipsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] target_address;
    logic [SIZE_W-1:0] run_length;
    logic [BYTE_W-1:0] byte_value;
    logic              record_end;

    modport source (output valid, output kind, output target_address, output run_length,
                    output byte_value, output record_end, input ready);
    modport sink   (input valid, input kind, input target_address, input run_length,
                    input byte_value, input record_end, output ready);
endinterface

>>> sv/ips_patch_stream_parser.sv
// ips patch stream parser: top level, input register, parser, result register
// depends on ipsp_pkg, ipsp_if, ipsp_in_stage, ipsp_parser, ipsp_out_stage
//
//  channel    dir  handshake     payload
//  i_item     in   valid/ready   patch_byte[7:0], last_byte
//  o_result   out  valid/ready   kind[2:0], target_address[24:0], run_length[15:0],
//                                byte_value[7:0], record_end
//  i_cfg_*    in   write enable  patch_length[23:0]
//
// one item per cycle unless the result side stalls; an item goes into the input register,
// its result into the result register, set by the single parser step between them
// items that give no result pass through without occupying the result register
// a stalled result holds the parser; the input register still takes one more item
// synchronous active-low reset clears control state and sets patch_length to all ones
`include "ips_patch_stream_parser_defines.svh"

module ips_patch_stream_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ipsp_in_if.sink                          i_item,
    ipsp_out_if.source                       o_result,
    input  logic                             i_cfg_we,
    input  logic [ipsp_pkg::PATCH_LEN_W-1:0] i_cfg_data
);
    import ipsp_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    out_valid;
    logic    in_ready;

    assign in_item.patch_byte = i_item.patch_byte;
    assign in_item.last_byte  = i_item.last_byte;
    assign i_item.ready       = in_ready;

    ipsp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .i_item    (in_item),
        .o_ready   (in_ready),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    ipsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_step      (stage_valid && advance),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ipsp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_res_valid (stage_valid && res_valid),
        .i_res       (res),
        .i_ready     (o_result.ready),
        .o_advance   (advance),
        .o_valid     (out_valid),
        .o_res       (out_res)
    );

    assign o_result.valid          = out_valid;
    assign o_result.kind           = out_res.kind;
    assign o_result.target_address = out_res.target_address;
    assign o_result.run_length     = out_res.run_length;
    assign o_result.byte_value     = out_res.byte_value;
    assign o_result.record_end     = out_res.record_end;

    // end, size error and truncation carry nothing but their kind
    `IPSP_ASSERT_NOW(a_status_fields_zero, i_clk, i_rst_n,
        out_valid && out_res.kind != K_DATA && out_res.kind != K_RUN,
        out_res.target_address == '0 && out_res.run_length == '0 &&
        out_res.byte_value == '0 && !out_res.record_end)

    // a fill run never marks a record end
    `IPSP_ASSERT_NOW(a_run_no_rend, i_clk, i_rst_n,
        out_valid && out_res.kind == K_RUN, !out_res.record_end)

    // a held item stays in the input register while the result side is stalled
    `IPSP_ASSERT_NEXT(a_stall_holds_item, i_clk, i_rst_n,
        stage_valid && !advance, stage_valid && $stable(stage_item))

    // an accepted item lands in the input register
    `IPSP_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n,
        i_item.valid && in_ready, stage_valid)
endmodule

>>> sv/ipsp_in_stage.sv
// input register stage: holds one accepted patch byte until the parser steps
// depends on ipsp_pkg
module ipsp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ipsp_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_advance,
    output logic           o_valid,
    output ipsp_pkg::t_item o_item
);
    import ipsp_pkg::*;

    logic  r_valid;
    t_item r_item;

    // the slot frees up whenever the parser consumes its item
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

>>> sv/ipsp_parser.sv
// record parser: phase state, field assembly and result formation per byte
// depends on ipsp_pkg
module ipsp_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ipsp_pkg::PATCH_LEN_W-1:0] i_cfg_data,
    input  logic                             i_step,
    input  ipsp_pkg::t_item                  i_item,
    output logic                             o_res_valid,
    output ipsp_pkg::t_result                o_res
);
    import ipsp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_OFFSET = 3'd1,
        PH_SIZE   = 3'd2,
        PH_DATA   = 3'd3,
        PH_RUNLEN = 3'd4,
        PH_FILL   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    logic [PATCH_LEN_W-1:0] r_patch_length;
    t_phase                 r_phase,        n_phase;
    logic [COUNT_W-1:0]     r_field_count,  n_field_count;
    logic [OFFSET_W-1:0]    r_record_offset, n_record_offset;
    logic [SIZE_W-1:0]      r_record_size,  n_record_size;
    logic [SIZE_W-1:0]      r_data_index,   n_data_index;

    logic [COUNT_W-1:0]  cnt_inc;
    logic [OFFSET_W-1:0] off_shift;
    logic [SIZE_W-1:0]   size_shift;
    logic [SIZE_W:0]     idx_inc;
    logic                rend;
    logic                boundary;
    logic                hit;
    t_result             res;

    assign cnt_inc    = r_field_count + 3'd1;
    assign off_shift  = {r_record_offset[OFFSET_W-BYTE_W-1:0], i_item.patch_byte};
    assign size_shift = {r_record_size[SIZE_W-BYTE_W-1:0], i_item.patch_byte};
    assign idx_inc    = {1'b0, r_data_index} + {{SIZE_W{1'b0}}, 1'b1};
    assign rend       = idx_inc >= {1'b0, r_record_size};

    always_comb begin
        n_phase         = r_phase;
        n_field_count   = r_field_count;
        n_record_offset = r_record_offset;
        n_record_size   = r_record_size;
        n_data_index    = r_data_index;
        boundary        = 1'b0;
        hit             = 1'b0;
        res             = '0;

        case (r_phase)
            PH_HEADER: begin
                n_field_count = cnt_inc;
                if (cnt_inc >= HEADER_LEN) begin
                    n_phase       = PH_OFFSET;
                    n_field_count = '0;
                end
                boundary = 1'b1;
            end
            PH_OFFSET: begin
                n_record_offset = off_shift;
                n_field_count   = cnt_inc;
                if (cnt_inc >= OFFSET_BYTES) begin
                    n_field_count = '0;
                    if (off_shift == EOF_MARK) begin
                        res.kind = K_END;
                        hit      = 1'b1;
                        n_phase  = PH_DONE;
                        boundary = 1'b1;
                    end else begin
                        n_phase       = PH_SIZE;
                        n_record_size = '0;
                    end
                end
            end
            PH_SIZE: begin
                n_record_size = size_shift;
                n_field_count = cnt_inc;
                if (cnt_inc >= SIZE_BYTES) begin
                    n_field_count = '0;
                    n_data_index  = '0;
                    // a zero size is checked against the length too
                    if ({{(PATCH_LEN_W-SIZE_W){1'b0}}, size_shift} >= r_patch_length) begin
                        res.kind = K_SIZE_ERR;
                        hit      = 1'b1;
                        n_phase  = PH_DONE;
                        boundary = 1'b1;
                    end else if (size_shift == '0) begin
                        n_phase = PH_RUNLEN;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res.kind           = K_DATA;
                res.target_address = {1'b0, r_record_offset}
                                   + {{(ADDR_W-SIZE_W){1'b0}}, r_data_index};
                res.byte_value     = i_item.patch_byte;
                res.record_end     = rend;
                hit                = 1'b1;
                n_data_index       = idx_inc[SIZE_W-1:0];
                if (rend) begin
                    n_phase         = PH_OFFSET;
                    n_record_offset = '0;
                    n_data_index    = '0;
                    boundary        = 1'b1;
                end
            end
            PH_RUNLEN: begin
                n_record_size = size_shift;
                n_field_count = cnt_inc;
                if (cnt_inc >= SIZE_BYTES) begin
                    n_field_count = '0;
                    n_phase       = PH_FILL;
                end
            end
            PH_FILL: begin
                res.kind           = K_RUN;
                res.target_address = {1'b0, r_record_offset};
                res.run_length     = r_record_size;
                res.byte_value     = i_item.patch_byte;
                hit                = 1'b1;
                n_phase            = PH_OFFSET;
                n_record_offset    = '0;
                n_record_size      = '0;
                boundary           = 1'b1;
            end
            default: begin
                // done: swallow bytes until the last flag
                n_phase  = PH_DONE;
                boundary = 1'b1;
            end
        endcase

        if (i_item.last_byte) begin
            if (!boundary) begin
                res      = '0;
                res.kind = K_TRUNC;
                hit      = 1'b1;
            end
            n_phase         = PH_HEADER;
            n_field_count   = '0;
            n_record_offset = '0;
            n_record_size   = '0;
            n_data_index    = '0;
        end
    end

    assign o_res_valid = hit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_length  <= PATCH_LEN_RST;
            r_phase         <= PH_HEADER;
            r_field_count   <= '0;
            r_record_offset <= '0;
            r_record_size   <= '0;
            r_data_index    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_patch_length <= i_cfg_data;
            end
            if (i_step) begin
                r_phase         <= n_phase;
                r_field_count   <= n_field_count;
                r_record_offset <= n_record_offset;
                r_record_size   <= n_record_size;
                r_data_index    <= n_data_index;
            end
        end
    end
endmodule

>>> sv/ipsp_out_stage.sv
// result register: holds one parse result until the sink takes it
// depends on ipsp_pkg
module ipsp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_res_valid,
    input  ipsp_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_advance,
    output logic              o_valid,
    output ipsp_pkg::t_result o_res
);
    import ipsp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room downstream when empty or being taken this cycle
    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end
endmodule

>>> tb/sv/tb_top.sv
// testbench for the ips patch stream parser: random and directed patch streams
// against an in-bench parser model, results checked in order field by field
// depends on ipsp_pkg, ipsp_if and ips_patch_stream_parser
`timescale 1ns / 100ps

module tb_top;
    import ipsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PHASE_ITEMS  = 215;

    typedef enum logic [2:0] {
        ST_HEADER, ST_OFFSET, ST_SIZE, ST_DATA, ST_RUNLEN, ST_FILL, ST_DONE
    } t_parse_phase;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic [BYTE_W-1:0]      in_byte   = '0;
    logic                   in_last   = 1'b0;
    logic                   out_ready = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [PATCH_LEN_W-1:0] cfg_data  = '0;

    ipsp_in_if  item_if ();
    ipsp_out_if result_if ();

    assign item_if.valid      = in_valid;
    assign item_if.patch_byte = in_byte;
    assign item_if.last_byte  = in_last;
    assign result_if.ready    = out_ready;

    ips_patch_stream_parser DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state, reset values
    t_parse_phase           ph       = ST_HEADER;
    logic [COUNT_W-1:0]     fcnt     = '0;
    logic [OFFSET_W-1:0]    rec_off  = '0;
    logic [SIZE_W-1:0]      rec_size = '0;
    logic [SIZE_W-1:0]      idx      = '0;
    logic [PATCH_LEN_W-1:0] len_limit = PATCH_LEN_RST;

    t_item       patch_stream [$];
    t_result     due_results [$];
    logic [7:0]  patch_buf [$];

    bit          idle_on = 1'b1;
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned kind_count [8];

    logic [PATCH_LEN_W-1:0] len_plan [6] = '{24'd0, 24'd1, 24'd24, 24'hFFFF, 24'd300,
                                             24'hFFFFFF};

    function automatic void parse_patch_byte(input t_item it);
        t_result r;
        logic    has_result;
        logic    boundary;
        logic    rend;
        r          = '0;
        has_result = 1'b0;
        boundary   = 1'b0;
        case (ph)
            ST_HEADER: begin
                fcnt = fcnt + 3'd1;
                if (fcnt >= HEADER_LEN) begin
                    ph   = ST_OFFSET;
                    fcnt = '0;
                end
                boundary = 1'b1;
            end
            ST_OFFSET: begin
                rec_off = {rec_off[15:0], it.patch_byte};
                fcnt    = fcnt + 3'd1;
                if (fcnt >= OFFSET_BYTES) begin
                    fcnt = '0;
                    if (rec_off == EOF_MARK) begin
                        r.kind     = K_END;
                        has_result = 1'b1;
                        ph         = ST_DONE;
                        boundary   = 1'b1;
                    end else begin
                        ph       = ST_SIZE;
                        rec_size = '0;
                    end
                end
            end
            ST_SIZE: begin
                rec_size = {rec_size[7:0], it.patch_byte};
                fcnt     = fcnt + 3'd1;
                if (fcnt >= SIZE_BYTES) begin
                    fcnt = '0;
                    idx  = '0;
                    if ({8'd0, rec_size} >= len_limit) begin
                        r.kind     = K_SIZE_ERR;
                        has_result = 1'b1;
                        ph         = ST_DONE;
                        boundary   = 1'b1;
                    end else if (rec_size == '0) begin
                        ph = ST_RUNLEN;
                    end else begin
                        ph = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                rend               = ({1'b0, idx} + 17'd1) >= {1'b0, rec_size};
                r.kind             = K_DATA;
                r.target_address   = {1'b0, rec_off} + {9'd0, idx};
                r.byte_value       = it.patch_byte;
                r.record_end       = rend;
                has_result         = 1'b1;
                idx                = idx + 16'd1;
                if (rend) begin
                    ph       = ST_OFFSET;
                    rec_off  = '0;
                    idx      = '0;
                    boundary = 1'b1;
                end
            end
            ST_RUNLEN: begin
                rec_size = {rec_size[7:0], it.patch_byte};
                fcnt     = fcnt + 3'd1;
                if (fcnt >= SIZE_BYTES) begin
                    fcnt = '0;
                    ph   = ST_FILL;
                end
            end
            ST_FILL: begin
                r.kind           = K_RUN;
                r.target_address = {1'b0, rec_off};
                r.run_length     = rec_size;
                r.byte_value     = it.patch_byte;
                has_result       = 1'b1;
                ph               = ST_OFFSET;
                rec_off          = '0;
                rec_size         = '0;
                boundary         = 1'b1;
            end
            default: begin
                ph       = ST_DONE;
                boundary = 1'b1;
            end
        endcase
        if (it.last_byte) begin
            // last flag inside a record replaces whatever this byte gave
            if (!boundary) begin
                r          = '0;
                r.kind     = K_TRUNC;
                has_result = 1'b1;
            end
            ph       = ST_HEADER;
            fcnt     = '0;
            rec_off  = '0;
            rec_size = '0;
            idx      = '0;
        end
        if (has_result)
            due_results.push_back(r);
    endfunction

    function automatic void add_be(input logic [23:0] v, input int nbytes);
        for (int i = nbytes; i > 0; i--)
            patch_buf.push_back(v[8*i-1 -: 8]);
    endfunction

    // moves the buffered patch into the stream, last flag on its final byte
    function automatic int unsigned flush_patch();
        t_item       it;
        int unsigned n;
        n = patch_buf.size();
        for (int unsigned i = 0; i < n; i++) begin
            it.patch_byte = patch_buf[i];
            it.last_byte  = (i == n - 1);
            patch_stream.push_back(it);
        end
        patch_buf.delete();
        return n;
    endfunction

    function automatic int unsigned add_patch();
        int unsigned mode;
        int unsigned n_rec;
        int unsigned lim;
        int unsigned max_sz;
        int unsigned sz;
        int unsigned keep;
        int unsigned n;
        logic [23:0] off;
        bit          stopped;
        t_item       it;
        patch_buf.delete();
        mode    = $urandom_range(0, 11);
        lim     = len_limit;
        stopped = 1'b0;
        if (mode == 11) begin
            // noise: random bytes, last flags scattered, closed by a last
            n = $urandom_range(1, 20);
            for (int unsigned i = 0; i < n; i++) begin
                it.patch_byte = 8'($urandom_range(0, 255));
                it.last_byte  = (i == n - 1) || ($urandom_range(0, 5) == 0);
                patch_stream.push_back(it);
            end
            return n;
        end
        for (int i = 0; i < 5; i++)
            patch_buf.push_back(8'($urandom_range(0, 255)));
        if (mode == 10) begin
            keep = $urandom_range(1, 5);
            while (patch_buf.size() > keep)
                void'(patch_buf.pop_back());
            return flush_patch();
        end
        n_rec = $urandom_range(0, 6);
        for (int unsigned k = 0; k < n_rec && !stopped; k++) begin
            if ($urandom_range(0, 7) == 0)
                off = 24'hFFFF00 | 24'($urandom_range(0, 255));
            else
                off = 24'($urandom_range(0, 24'hFFFFFF));
            if (off == EOF_MARK)
                off = off ^ 24'h1;
            add_be(off, 3);
            max_sz = ($urandom_range(0, 19) == 0) ? 64 : 12;
            if (lim == 0)
                max_sz = 0;
            else if (lim - 1 < max_sz)
                max_sz = lim - 1;
            if ($urandom_range(0, 19) == 0 && lim <= 32'hFFFF) begin
                add_be(24'($urandom_range(lim, 32'hFFFF)), 2);
                stopped = 1'b1;
            end else if (max_sz == 0 || $urandom_range(0, 3) == 0) begin
                add_be(24'd0, 2);
                case ($urandom_range(0, 7))
                    0:       add_be(24'd0, 2);
                    1:       add_be(24'hFFFF, 2);
                    default: add_be(24'($urandom_range(0, 32'hFFFF)), 2);
                endcase
                patch_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                sz = $urandom_range(1, max_sz);
                add_be(24'(sz), 2);
                for (int unsigned j = 0; j < sz; j++)
                    patch_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (stopped || mode <= 4) begin
            if (!stopped)
                add_be(EOF_MARK, 3);
            // trailing bytes that the block has to ignore
            n = $urandom_range(0, 4);
            for (int unsigned j = 0; j < n; j++)
                patch_buf.push_back(8'($urandom_range(0, 255)));
        end else if (mode >= 8 && patch_buf.size() > 6) begin
            keep = $urandom_range(6, patch_buf.size() - 1);
            while (patch_buf.size() > keep)
                void'(patch_buf.pop_back());
        end
        return flush_patch();
    endfunction

    task automatic fill_random(input int unsigned n_items);
        int unsigned pushed;
        pushed = 0;
        while (pushed < n_items)
            pushed += add_patch();
    endtask

    // waits until the sender is empty and every due result has come
    task automatic drain();
        while (patch_stream.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_patch_length(input logic [PATCH_LEN_W-1:0] v);
        drain();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        len_limit = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin : byte_driver
        logic  nv;
        t_item taken;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            nv = 1'b0;
            if (in_valid && item_if.ready) begin
                taken = patch_stream.pop_front();
                parse_patch_byte(taken);
                bytes_taken++;
                if (idle_on && $urandom_range(0, 9) == 0)
                    in_gap = $urandom_range(1, 18);
            end
            if (in_valid && !item_if.ready) begin
                nv = 1'b1;
            end else if (in_gap > 0) begin
                in_gap--;
            end else if (patch_stream.size() > 0) begin
                nv = 1'b1;
                in_byte <= patch_stream[0].patch_byte;
                in_last <= patch_stream[0].last_byte;
            end
            in_valid <= nv;
        end
    end

    always @(posedge clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && result_if.valid) begin
                got.kind           = t_kind'(result_if.kind);
                got.target_address = result_if.target_address;
                got.run_length     = result_if.run_length;
                got.byte_value     = result_if.byte_value;
                got.record_end     = result_if.record_end;
                results_seen++;
                kind_count[got.kind]++;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d %h %h %h %b",
                             $time, got.kind, got.target_address, got.run_length,
                             got.byte_value, got.record_end);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %0d %h %h %h %b, actual %0d %h %h %h %b",
                                 $time, want.kind, want.target_address, want.run_length,
                                 want.byte_value, want.record_end, got.kind,
                                 got.target_address, got.run_length, got.byte_value,
                                 got.record_end);
                        mismatch_count++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 15) == 0)
                    out_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time, due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // header with extreme bytes, a literal record at the top offset that
        // carries into bit 24, an empty run, then the end marker on a last byte
        patch_buf.push_back(8'h00);
        patch_buf.push_back(8'hFF);
        patch_buf.push_back(8'h55);
        patch_buf.push_back(8'hAA);
        patch_buf.push_back(8'h0F);
        add_be(24'hFFFFFF, 3);
        add_be(24'd2, 2);
        patch_buf.push_back(8'hFF);
        patch_buf.push_back(8'h00);
        add_be(24'd0, 3);
        add_be(24'd0, 2);
        add_be(24'd0, 2);
        patch_buf.push_back(8'h5A);
        add_be(EOF_MARK, 3);
        void'(flush_patch());
        // short header closed by a last flag
        patch_buf.push_back(8'h12);
        patch_buf.push_back(8'h34);
        void'(flush_patch());
        fill_random(PHASE_ITEMS);
        for (int p = 0; p < 6; p++) begin
            set_patch_length(len_plan[p]);
            if (p == 5)
                idle_on = 1'b0;
            @(negedge clk);
            fill_random(PHASE_ITEMS);
        end
        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d patch bytes over 7 patch length settings, %0d results checked",
                 bytes_taken, results_seen);
        $display("results by kind: data %0d, run %0d, end %0d, size error %0d, truncated %0d",
                 kind_count[K_DATA], kind_count[K_RUN], kind_count[K_END],
                 kind_count[K_SIZE_ERR], kind_count[K_TRUNC]);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ipsp_pkg.sv
sv/ipsp_if.sv
sv/ipsp_in_stage.sv
sv/ipsp_parser.sv
sv/ipsp_out_stage.sv
sv/ips_patch_stream_parser.sv
tb/sv/tb_top.sv
